// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, clocked on clock, off during reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/lsrc_pkg.sv =====
// ----------------------------------------------------------------------------
// lsrc_pkg
// shared types and constants of the segment clipper
// ----------------------------------------------------------------------------
package lsrc_pkg;

   localparam int unsigned COORD_W     = 32;
   localparam int unsigned DIV_STEPS   = 2;
   localparam int unsigned DIV_STAGES  = COORD_W / DIV_STEPS;
   localparam int unsigned FLAG_START  = 0;
   localparam int unsigned FLAG_END    = 1;

   localparam logic signed [31:0] LEFT_RESET   = 32'sd0;
   localparam logic signed [31:0] RIGHT_RESET  = 32'sd639;
   localparam logic signed [31:0] TOP_RESET    = 32'sd0;
   localparam logic signed [31:0] BOTTOM_RESET = 32'sd479;

   typedef enum logic [1:0] {
      REG_LEFT   = 2'd0,
      REG_RIGHT  = 2'd1,
      REG_TOP    = 2'd2,
      REG_BOTTOM = 2'd3
   } reg_idx_type;

   typedef enum logic [1:0] {
      EDGE_RIGHT,
      EDGE_LEFT,
      EDGE_TOP,
      EDGE_BOTTOM
   } edge_type;

   typedef struct packed {
      logic              vis;
      logic [1:0]        flags;
      logic signed [31:0] x1;
      logic signed [31:0] y1;
      logic signed [31:0] x2;
      logic signed [31:0] y2;
   } seg_type;

endpackage

// ===== hw/rtl/lsrc_req_if.sv =====
// ----------------------------------------------------------------------------
// lsrc_req_if
// segment request channel, one segment per beat
// ----------------------------------------------------------------------------
interface lsrc_req_if;
   logic              valid;
   logic              ready;
   logic signed [31:0] start_x;
   logic signed [31:0] start_y;
   logic signed [31:0] end_x;
   logic signed [31:0] end_y;

   modport source (output valid, start_x, start_y, end_x, end_y, input ready);
   modport sink   (input valid, start_x, start_y, end_x, end_y, output ready);
endinterface

// ===== hw/rtl/lsrc_rsp_if.sv =====
// ----------------------------------------------------------------------------
// lsrc_rsp_if
// clip result channel, one clipped segment per beat
// ----------------------------------------------------------------------------
interface lsrc_rsp_if;
   logic              valid;
   logic              ready;
   logic              visible;
   logic [1:0]        clip_flags;
   logic signed [31:0] out_start_x;
   logic signed [31:0] out_start_y;
   logic signed [31:0] out_end_x;
   logic signed [31:0] out_end_y;

   modport source (output valid, visible, clip_flags, out_start_x, out_start_y,
                   out_end_x, out_end_y, input ready);
   modport sink   (input valid, visible, clip_flags, out_start_x, out_start_y,
                   out_end_x, out_end_y, output ready);
endinterface

// ===== hw/rtl/line_segment_rect_clip.sv =====
// ----------------------------------------------------------------------------
// line_segment_rect_clip
// clips line segments against a configured rectangle; unless the result stalls, one segment per cycle
// ----------------------------------------------------------------------------
// usage:
//   req_chan carries a segment (start and end point) per beat, rsp_chan the
//   visible bit, the two moved-end flags and the clipped endpoints per beat
//   edges are taken right, left, top, bottom; each is a 19-register slice:
//   classify, 32x32 multiply, 16 divide stages of 2 quotient bits, fix-up
//   a beat runs through the four slices in order, each register by register;
//   the last fix-up register drives rsp_chan; throughput is one segment per
//   cycle unless the result stalls, and the pipelined divider sets the depth
//   the rectangle lives in four apb registers at byte address 0, 4, 8, 12
//   (left, right, top, bottom); write only while the pipeline is empty
//   reset empties the pipeline and loads the rectangle 0..639 by 0..479
//   when the receiver stalls with a result waiting, the whole pipeline
//   freezes and req_chan.ready drops in the same cycle; nothing is lost
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module line_segment_rect_clip (
   input  logic        clock,
   input  logic        reset,
   lsrc_req_if.sink    req_chan,
   lsrc_rsp_if.source  rsp_chan,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   // rectangle registers
   logic signed [31:0] left_ff, right_ff, top_ff, bottom_ff;
   lsrc_pkg::reg_idx_type reg_idx;

   // chain of edge slices
   logic               stage_valid [5];
   lsrc_pkg::seg_type  stage_seg   [5];
   logic signed [31:0] edge_bound  [4];
   lsrc_pkg::edge_type edge_kind   [4];
   logic               advance;

   assign reg_idx = lsrc_pkg::reg_idx_type'(paddr[3:2]);
   assign pready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff   <= lsrc_pkg::LEFT_RESET;
         right_ff  <= lsrc_pkg::RIGHT_RESET;
         top_ff    <= lsrc_pkg::TOP_RESET;
         bottom_ff <= lsrc_pkg::BOTTOM_RESET;
      end else if (psel && penable && pwrite) begin
         unique case (reg_idx)
            lsrc_pkg::REG_LEFT:   left_ff   <= pwdata;
            lsrc_pkg::REG_RIGHT:  right_ff  <= pwdata;
            lsrc_pkg::REG_TOP:    top_ff    <= pwdata;
            lsrc_pkg::REG_BOTTOM: bottom_ff <= pwdata;
            default: ;
         endcase
      end
   end

   // register readback
   always_comb begin
      unique case (reg_idx)
         lsrc_pkg::REG_LEFT:   prdata = left_ff;
         lsrc_pkg::REG_RIGHT:  prdata = right_ff;
         lsrc_pkg::REG_TOP:    prdata = top_ff;
         lsrc_pkg::REG_BOTTOM: prdata = bottom_ff;
         default:              prdata = '0;
      endcase
   end

   // the pipeline moves whenever the result register is empty or being taken
   assign advance        = !stage_valid[4] || rsp_chan.ready;
   assign req_chan.ready = advance;

   // incoming beat: visible, nothing moved yet
   assign stage_valid[0]     = req_chan.valid;
   assign stage_seg[0].vis   = 1'b1;
   assign stage_seg[0].flags = 2'b00;
   assign stage_seg[0].x1    = req_chan.start_x;
   assign stage_seg[0].y1    = req_chan.start_y;
   assign stage_seg[0].x2    = req_chan.end_x;
   assign stage_seg[0].y2    = req_chan.end_y;

   // fixed clip order
   assign edge_kind[0]  = lsrc_pkg::EDGE_RIGHT;
   assign edge_kind[1]  = lsrc_pkg::EDGE_LEFT;
   assign edge_kind[2]  = lsrc_pkg::EDGE_TOP;
   assign edge_kind[3]  = lsrc_pkg::EDGE_BOTTOM;
   assign edge_bound[0] = right_ff;
   assign edge_bound[1] = left_ff;
   assign edge_bound[2] = top_ff;
   assign edge_bound[3] = bottom_ff;

   for (genvar e = 0; e < 4; e++) begin : g_edge
      lsrc_edge u_edge (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .edge_kind (edge_kind[e]),
         .bound     (edge_bound[e]),
         .in_valid  (stage_valid[e]),
         .in_seg    (stage_seg[e]),
         .out_valid (stage_valid[e+1]),
         .out_seg   (stage_seg[e+1])
      );
   end

   // last slice register is the result register
   assign rsp_chan.valid       = stage_valid[4];
   assign rsp_chan.visible     = stage_seg[4].vis;
   assign rsp_chan.clip_flags  = stage_seg[4].flags;
   assign rsp_chan.out_start_x = stage_seg[4].x1;
   assign rsp_chan.out_start_y = stage_seg[4].y1;
   assign rsp_chan.out_end_x   = stage_seg[4].x2;
   assign rsp_chan.out_end_y   = stage_seg[4].y2;

   // pipeline comes out of reset empty
   `ASSERT_IMP(a_empty_after_reset, $past(reset), !rsp_chan.valid, "result after reset")

   // input is only held off by a stalled result
   `ASSERT_IMP(a_backpressure_source, req_chan.valid && !req_chan.ready,
      rsp_chan.valid && !rsp_chan.ready, "input stalled without output stall")

   // a moved start point of a visible segment sits on some edge
   `ASSERT_IMP(a_moved_start_on_edge,
      rsp_chan.valid && rsp_chan.visible && rsp_chan.clip_flags[lsrc_pkg::FLAG_START],
      (rsp_chan.out_start_x == left_ff) || (rsp_chan.out_start_x == right_ff) ||
      (rsp_chan.out_start_y == top_ff) || (rsp_chan.out_start_y == bottom_ff),
      "moved start point off every edge")

endmodule

// ===== hw/rtl/lsrc_edge.sv =====
// ----------------------------------------------------------------------------
// lsrc_edge
// clips a segment against one edge: classify, multiply, pipelined divide, fix
// ----------------------------------------------------------------------------
module lsrc_edge (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  lsrc_pkg::edge_type edge_kind,
   input  logic signed [31:0] bound,
   input  logic               in_valid,
   input  lsrc_pkg::seg_type  in_seg,
   output logic               out_valid,
   output lsrc_pkg::seg_type  out_seg
);

   localparam int unsigned NStage = 2 + lsrc_pkg::DIV_STAGES;

   typedef enum logic [1:0] {
      ACT_PASS,
      ACT_REJECT,
      ACT_MOVE_END,
      ACT_MOVE_START
   } act_type;

   typedef struct packed {
      lsrc_pkg::seg_type  seg;
      act_type            act;
      logic               neg;
      logic signed [31:0] base;
      logic [31:0]        a;
      logic [31:0]        n;
      logic [31:0]        d;
      logic [31:0]        rem;
      logic [31:0]        low;
      logic [31:0]        quo;
   } stage_type;

   logic      swap;
   logic      low_side;
   logic      v_ff [NStage];
   stage_type pipe_ff [NStage];
   stage_type pipe_in [NStage];
   logic      out_valid_ff;
   lsrc_pkg::seg_type out_seg_ff;
   lsrc_pkg::seg_type out_seg_in;

   assign swap     = (edge_kind == lsrc_pkg::EDGE_TOP) || (edge_kind == lsrc_pkg::EDGE_BOTTOM);
   assign low_side = (edge_kind == lsrc_pkg::EDGE_LEFT) || (edge_kind == lsrc_pkg::EDGE_TOP);

   // classify both ends and form interpolation operands
   always_comb begin
      logic signed [31:0] p1, q1, p2, q2;
      logic signed [32:0] dq, dn, dd;
      logic out1, out2, in1, in2;
      p1 = swap ? in_seg.y1 : in_seg.x1;
      q1 = swap ? in_seg.x1 : in_seg.y1;
      p2 = swap ? in_seg.y2 : in_seg.x2;
      q2 = swap ? in_seg.x2 : in_seg.y2;
      out1 = low_side ? (p1 < bound) : (p1 > bound);
      out2 = low_side ? (p2 < bound) : (p2 > bound);
      in1  = low_side ? (p1 > bound) : (p1 < bound);
      in2  = low_side ? (p2 > bound) : (p2 < bound);
      dq = {q2[31], q2} - {q1[31], q1};
      dn = {bound[31], bound} - {p1[31], p1};
      dd = {p2[31], p2} - {p1[31], p1};
      pipe_in[0]      = '0;
      pipe_in[0].seg  = in_seg;
      pipe_in[0].base = q1;
      pipe_in[0].neg  = dq[32] ^ dn[32] ^ dd[32];
      pipe_in[0].a    = dq[32] ? (~dq[31:0] + 32'd1) : dq[31:0];
      pipe_in[0].n    = dn[32] ? (~dn[31:0] + 32'd1) : dn[31:0];
      pipe_in[0].d    = dd[32] ? (~dd[31:0] + 32'd1) : dd[31:0];
      if (!in_seg.vis) begin
         pipe_in[0].act = ACT_PASS;
      end else if (out1 && out2) begin
         pipe_in[0].act = ACT_REJECT;
      end else if (in1 && out2) begin
         pipe_in[0].act = ACT_MOVE_END;
      end else if (out1 && in2) begin
         pipe_in[0].act = ACT_MOVE_START;
      end else begin
         pipe_in[0].act = ACT_PASS;
      end
   end

   // product stage: high word seeds the remainder, quotient fits 32 bits
   always_comb begin
      pipe_in[1] = pipe_ff[0];
      {pipe_in[1].rem, pipe_in[1].low} = 64'(pipe_ff[0].a) * 64'(pipe_ff[0].n);
      pipe_in[1].quo = '0;
   end

   // restoring divide, a few quotient bits per stage
   for (genvar k = 2; k < NStage; k++) begin : g_div
      always_comb begin
         logic [32:0] trial;
         pipe_in[k] = pipe_ff[k-1];
         for (int i = 0; i < lsrc_pkg::DIV_STEPS; i++) begin
            trial = {pipe_in[k].rem, pipe_in[k].low[31]};
            pipe_in[k].low = {pipe_in[k].low[30:0], 1'b0};
            if (trial >= {1'b0, pipe_in[k].d}) begin
               pipe_in[k].rem = 32'(trial - {1'b0, pipe_in[k].d});
               pipe_in[k].quo = {pipe_in[k].quo[30:0], 1'b1};
            end else begin
               pipe_in[k].rem = trial[31:0];
               pipe_in[k].quo = {pipe_in[k].quo[30:0], 1'b0};
            end
         end
      end
   end

   // truncate toward zero and move the outside end
   always_comb begin
      stage_type          st;
      logic signed [33:0] t;
      logic signed [31:0] res;
      st = pipe_ff[NStage-1];
      t  = st.neg ? ({{2{st.base[31]}}, st.base} - {2'b00, st.quo})
                  : ({{2{st.base[31]}}, st.base} + {2'b00, st.quo});
      if (st.rem != 32'd0) begin
         if (!st.neg) begin
            if (t[33]) t = t + 34'sd1;
         end else begin
            if (!t[33] && (t != 34'sd0)) t = t - 34'sd1;
         end
      end
      res = t[31:0];
      out_seg_in = st.seg;
      case (st.act)
         ACT_REJECT: out_seg_in.vis = 1'b0;
         ACT_MOVE_END: begin
            out_seg_in.flags[lsrc_pkg::FLAG_END] = 1'b1;
            if (swap) begin
               out_seg_in.x2 = res;
               out_seg_in.y2 = bound;
            end else begin
               out_seg_in.x2 = bound;
               out_seg_in.y2 = res;
            end
         end
         ACT_MOVE_START: begin
            out_seg_in.flags[lsrc_pkg::FLAG_START] = 1'b1;
            if (swap) begin
               out_seg_in.x1 = res;
               out_seg_in.y1 = bound;
            end else begin
               out_seg_in.x1 = bound;
               out_seg_in.y1 = res;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NStage; k++) v_ff[k] <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         v_ff[0] <= in_valid;
         for (int k = 1; k < NStage; k++) v_ff[k] <= v_ff[k-1];
         out_valid_ff <= v_ff[NStage-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int k = 0; k < NStage; k++) pipe_ff[k] <= pipe_in[k];
         out_seg_ff <= out_seg_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_seg   = out_seg_ff;

endmodule

// ===== test/tb_line_segment_rect_clip.sv =====
// ----------------------------------------------------------------------------
// tb_line_segment_rect_clip
// self-checking bench: directed and random segments against several
// rectangles, with bursty sender, stalling receiver and a scoreboard that
// predicts every clipped beat
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

class clip_scoreboard;
   lsrc_pkg::seg_type pending[$];
   int errors = 0;
   logic signed [31:0] rect_left = lsrc_pkg::LEFT_RESET;
   logic signed [31:0] rect_right = lsrc_pkg::RIGHT_RESET;
   logic signed [31:0] rect_top = lsrc_pkg::TOP_RESET;
   logic signed [31:0] rect_bottom = lsrc_pkg::BOTTOM_RESET;

   // exact interpolation, whole value truncated toward zero
   // magnitudes keep the product inside 64 unsigned bits
   function automatic longint lerp(longint p1, longint q1, longint p2, longint q2,
                                   longint b);
      longint dq, dn, dd, t;
      longint unsigned a, n, d, prod, qm, rm;
      bit neg;
      dq = q2 - q1;
      dn = b - p1;
      dd = p2 - p1;
      neg = (dq < 0) ^ (dn < 0) ^ (dd < 0);
      a = (dq < 0) ? longint'(-dq) : dq;
      n = (dn < 0) ? longint'(-dn) : dn;
      d = (dd < 0) ? longint'(-dd) : dd;
      prod = a * n;
      qm = prod / d;
      rm = prod % d;
      t = neg ? (q1 - longint'(qm)) : (q1 + longint'(qm));
      if (rm != 0) begin
         if (!neg) begin
            if (t < 0) t = t + 1;
         end else begin
            if (t > 0) t = t - 1;
         end
      end
      return t;
   endfunction

   function automatic bit clip_edge(ref longint p1, ref longint q1, ref longint p2,
                                    ref longint q2, input longint b, input bit low_side,
                                    ref logic [1:0] flags);
      bit out1, out2, in1, in2;
      out1 = low_side ? (p1 < b) : (p1 > b);
      out2 = low_side ? (p2 < b) : (p2 > b);
      in1 = low_side ? (p1 > b) : (p1 < b);
      in2 = low_side ? (p2 > b) : (p2 < b);
      if (out1 && out2) return 0;
      if (in1 && out2) begin
         q2 = lerp(p1, q1, p2, q2, b);
         p2 = b;
         flags[lsrc_pkg::FLAG_END] = 1'b1;
      end else if (out1 && in2) begin
         q1 = lerp(p1, q1, p2, q2, b);
         p1 = b;
         flags[lsrc_pkg::FLAG_START] = 1'b1;
      end
      return 1;
   endfunction

   function void note_segment(logic signed [31:0] sx, logic signed [31:0] sy,
                              logic signed [31:0] ex, logic signed [31:0] ey);
      longint x1, y1, x2, y2;
      logic [1:0] flags;
      bit vis;
      lsrc_pkg::seg_type s;
      x1 = sx; y1 = sy; x2 = ex; y2 = ey;
      flags = 2'b00;
      vis = clip_edge(x1, y1, x2, y2, rect_right, 0, flags);
      if (vis) vis = clip_edge(x1, y1, x2, y2, rect_left, 1, flags);
      if (vis) vis = clip_edge(y1, x1, y2, x2, rect_top, 1, flags);
      if (vis) vis = clip_edge(y1, x1, y2, x2, rect_bottom, 0, flags);
      s.vis = vis;
      s.flags = flags;
      s.x1 = x1[31:0]; s.y1 = y1[31:0]; s.x2 = x2[31:0]; s.y2 = y2[31:0];
      pending.push_back(s);
   endfunction

   function void check_result(lsrc_pkg::seg_type got);
      lsrc_pkg::seg_type exp_seg;
      if (pending.size() == 0) begin
         $error("result beat with nothing expected");
         errors++;
         return;
      end
      exp_seg = pending.pop_front();
      if (got.vis !== exp_seg.vis) begin
         $error("visible: expected %0d, got %0d", exp_seg.vis, got.vis); errors++;
      end
      if (got.flags !== exp_seg.flags) begin
         $error("clip_flags: expected %0d, got %0d", exp_seg.flags, got.flags); errors++;
      end
      if (got.x1 !== exp_seg.x1) begin
         $error("out_start_x: expected %0d, got %0d", exp_seg.x1, got.x1); errors++;
      end
      if (got.y1 !== exp_seg.y1) begin
         $error("out_start_y: expected %0d, got %0d", exp_seg.y1, got.y1); errors++;
      end
      if (got.x2 !== exp_seg.x2) begin
         $error("out_end_x: expected %0d, got %0d", exp_seg.x2, got.x2); errors++;
      end
      if (got.y2 !== exp_seg.y2) begin
         $error("out_end_y: expected %0d, got %0d", exp_seg.y2, got.y2); errors++;
      end
   endfunction
endclass

module tb_line_segment_rect_clip;

   localparam int PIPE_DEPTH = 76;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [3:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic pready;
   bit rsp_stall_on = 1'b1;

   lsrc_req_if req_chan ();
   lsrc_rsp_if rsp_chan ();

   clip_scoreboard board = new();

   line_segment_rect_clip dut (
      .clock(clock),
      .reset(reset),
      .req_chan(req_chan.sink),
      .rsp_chan(rsp_chan.source),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   always #1 clock = ~clock;

   initial begin
      req_chan.valid = 1'b0;
      req_chan.start_x = '0;
      req_chan.start_y = '0;
      req_chan.end_x = '0;
      req_chan.end_y = '0;
      rsp_chan.ready = 1'b0;
   end

   // receiver: stalls on its own pattern, changing style every so often
   always @(posedge clock) begin
      int stall_pct;
      stall_pct = 0;
      if (rsp_stall_on) stall_pct = (($time / 600) % 3 == 0) ? 0 : 40;
      if (reset) rsp_chan.ready <= 1'b0;
      else rsp_chan.ready <= ($urandom_range(99) >= stall_pct);
   end

   // result beats go to the scoreboard
   always @(posedge clock) begin
      lsrc_pkg::seg_type got;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got.vis = rsp_chan.visible;
         got.flags = rsp_chan.clip_flags;
         got.x1 = rsp_chan.out_start_x;
         got.y1 = rsp_chan.out_start_y;
         got.x2 = rsp_chan.out_end_x;
         got.y2 = rsp_chan.out_end_y;
         board.check_result(got);
      end
   end

   // one apb write: setup then access, register taken at access edge
   task automatic write_reg(lsrc_pkg::reg_idx_type idx, logic signed [31:0] value);
      @(posedge clock);
      psel <= 1'b1;
      pwrite <= 1'b1;
      penable <= 1'b0;
      paddr <= 4'(idx) << 2;
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      case (idx)
         lsrc_pkg::REG_LEFT: board.rect_left = value;
         lsrc_pkg::REG_RIGHT: board.rect_right = value;
         lsrc_pkg::REG_TOP: board.rect_top = value;
         default: board.rect_bottom = value;
      endcase
   endtask

   task automatic set_rect(logic signed [31:0] l, logic signed [31:0] r,
                           logic signed [31:0] t, logic signed [31:0] b);
      write_reg(lsrc_pkg::REG_LEFT, l);
      write_reg(lsrc_pkg::REG_RIGHT, r);
      write_reg(lsrc_pkg::REG_TOP, t);
      write_reg(lsrc_pkg::REG_BOTTOM, b);
   endtask

   // drive one segment beat and hold it until accepted
   task automatic send_segment(logic signed [31:0] sx, logic signed [31:0] sy,
                               logic signed [31:0] ex, logic signed [31:0] ey);
      req_chan.valid <= 1'b1;
      req_chan.start_x <= sx;
      req_chan.start_y <= sy;
      req_chan.end_x <= ex;
      req_chan.end_y <= ey;
      do @(posedge clock); while (!req_chan.ready);
      board.note_segment(sx, sy, ex, ey);
   endtask

   task automatic idle_cycles(int n);
      req_chan.valid <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   // drain: wait for all expected beats, then the pipeline depth
   task automatic drain();
      idle_cycles(1);
      while (board.pending.size() != 0) @(posedge clock);
      repeat (PIPE_DEPTH + 4) @(posedge clock);
   endtask

   // coordinate near an edge most of the time, anything otherwise
   function automatic logic signed [31:0] pick_coord(logic signed [31:0] lo,
                                                     logic signed [31:0] hi);
      longint base, v;
      case ($urandom_range(9))
         0, 1: return $urandom;
         2: return lo;
         3: return hi;
         default: begin
            base = ($urandom_range(1)) ? lo : hi;
            v = base + $signed($urandom_range(400)) - 200;
            if (v > 64'sd2147483647) v = 64'sd2147483647;
            if (v < -64'sd2147483648) v = -64'sd2147483648;
            return v[31:0];
         end
      endcase
   endfunction

   task automatic random_phase(int count);
      int sent, burst;
      sent = 0;
      while (sent < count) begin
         burst = $urandom_range(1, 30);
         repeat (burst) begin
            if (sent < count) begin
               send_segment(pick_coord(board.rect_left, board.rect_right),
                            pick_coord(board.rect_top, board.rect_bottom),
                            pick_coord(board.rect_left, board.rect_right),
                            pick_coord(board.rect_top, board.rect_bottom));
               sent++;
            end
         end
         if ($urandom_range(3) != 0) idle_cycles($urandom_range(1, 12));
      end
   endtask

   localparam logic signed [31:0] S_MAX = 32'sh7fffffff;
   localparam logic signed [31:0] S_MIN = 32'sh80000000;

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed, reset rectangle 0..639 x 0..479
      send_segment(10, 10, 100, 100);        // fully inside
      send_segment(-10, 50, 700, 60);        // crosses left and right
      send_segment(700, 10, 800, 20);        // both right, rejected
      send_segment(-5, -5, -50, 600);        // both left, rejected
      send_segment(100, -20, 200, -1);       // both above
      send_segment(100, 500, 300, 900);      // both below
      send_segment(639, 0, 0, 479);          // ends on edges
      send_segment(320, -100, 320, 900);     // vertical crossing top and bottom
      send_segment(700, 700, -100, -100);    // diagonal through the corner at 0,0
      send_segment(700, 10, 300, 500);       // right move then bottom move
      send_segment(-7, 3, 5, -9);            // truncation with negative values
      send_segment(S_MIN, S_MIN, S_MAX, S_MAX);
      send_segment(S_MAX, S_MIN, S_MIN, S_MAX);
      send_segment(S_MAX, S_MAX, S_MAX, S_MAX);
      send_segment(S_MIN, 5, S_MIN, 7);
      drain();

      // extreme rectangle, full range
      set_rect(S_MIN, S_MAX, S_MIN, S_MAX);
      send_segment(S_MIN, S_MAX, S_MAX, S_MIN);
      send_segment(0, 0, -1, -1);
      // inverted rectangle
      drain();
      set_rect(100, -100, 50, -50);
      send_segment(0, 0, 10, 10);
      send_segment(-200, 0, 200, 0);
      drain();
      // degenerate single point rectangle
      set_rect(-3, -3, 7, 7);
      send_segment(-10, 0, 10, 20);
      send_segment(-3, 7, -3, 7);
      drain();

      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: set_rect(0, 639, 0, 479);
            1: set_rect(S_MIN, S_MAX, S_MIN, S_MAX);
            2: set_rect(-1000000, 1000000, -2000, 2000);
            3: set_rect(S_MAX - 10, S_MAX, S_MIN, S_MIN + 10);
            4: set_rect(500, -500, 300, -300);
            default: set_rect($urandom, $urandom, $urandom, $urandom);
         endcase
         rsp_stall_on = (phase != 2);
         random_phase(310);
         // hold off until everything has come back
         drain();
      end

      while (board.pending.size() != 0) @(posedge clock);
      repeat (PIPE_DEPTH + 10) @(posedge clock);
      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // watchdog
   initial begin
      #2000000;
      $display("Some tests failed");
      $finish;
   end
endmodule
